// ===== hdl/kce_pkg.sv =====
// ----------------------------------------------------------------------------
// kce_pkg
// shared types and constants for the keyframe cursor engine
// ----------------------------------------------------------------------------
package kce_pkg;

  localparam int FRAMES_DEF    = 64;
  localparam int TIME_BITS_DEF = 32;
  localparam int MIN_FRAMES    = 2;

  localparam int CFG_W      = 7;
  localparam int OP_W       = 2;
  localparam int INDEX_W    = 6;
  localparam int TIME_W     = 32;
  localparam int SEG_W      = 6;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_SEEK    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // table read address source
  typedef enum logic [2:0] {
    ADDR_ZERO,
    ADDR_LAST,
    ADDR_SEG,
    ADDR_SEG1,
    ADDR_MID,
    ADDR_STEP
  } addr_sel_t;

  typedef struct packed {
    logic      load;
    logic      ram_we;
    logic      ok_set;
    addr_sel_t addr_sel;
    logic      cap_t0;
    logic      cap_tl;
    logic      cap_lo;
    logic      cap_hi;
    logic      seek_init;
    logic      seek_step;
    logic      seek_done;
    logic      adv_add;
    logic      adv_step;
    logic      adv_cap;
    logic      out_load;
  } kce_cmd_t;

  typedef struct packed {
    op_t  op;
    logic idx_ok;
    logic n_lt2;
    logic span_bad;
    logic seek_last;
    logic mid_bad;
    logic adv_bad;
    logic lo_gt_hi;
    logic in_range;
    logic adv_clamp;
    logic step_last;
  } kce_stat_t;

endpackage

// ===== hdl/kce_ram.sv =====
// ----------------------------------------------------------------------------
// kce_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module kce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/kce_dp.sv =====
// ----------------------------------------------------------------------------
// kce_dp
// datapath: keyframe table, cursor registers, search bounds, saturating math
// ----------------------------------------------------------------------------
module kce_dp #(
  parameter int MAX_FRAMES = 64,
  parameter int TIME_BITS  = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [kce_pkg::OP_W-1:0]        opcode,
  input  logic [kce_pkg::INDEX_W-1:0]     frame_index,
  input  logic signed [kce_pkg::TIME_W-1:0] time_value,
  input  logic                            loop_enable,
  input  logic                            cfg_valid,
  input  logic [kce_pkg::CFG_W-1:0]       cfg_data,
  input  kce_pkg::kce_cmd_t               cmd,
  output kce_pkg::kce_stat_t              status,
  output logic                            ok,
  output logic [kce_pkg::SEG_W-1:0]       segment_index,
  output logic signed [kce_pkg::TIME_W-1:0] cursor_time
);

  import kce_pkg::*;

  localparam int TB = TIME_BITS;
  localparam int AW = $clog2(MAX_FRAMES);
  localparam int CW = ((AW > CFG_W) ? AW : CFG_W) + 1;
  localparam int IW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

  localparam logic signed [TB-1:0] TMAX = {1'b0, {(TB-1){1'b1}}};
  localparam logic signed [TB-1:0] TMIN = {1'b1, {(TB-1){1'b0}}};
  localparam logic signed [63:0] IN_MAX = (64'sd1 <<< (TB-1)) - 64'sd1;
  localparam logic signed [63:0] IN_MIN = -IN_MAX - 64'sd1;

  function automatic logic signed [TB-1:0] sat_add(input logic signed [TB-1:0] a,
                                                   input logic signed [TB-1:0] b);
    logic signed [TB:0] s;
    s = {a[TB-1], a} + {b[TB-1], b};
    if (s[TB] != s[TB-1]) return s[TB] ? TMIN : TMAX;
    return s[TB-1:0];
  endfunction

  function automatic logic signed [TB-1:0] sat_sub(input logic signed [TB-1:0] a,
                                                   input logic signed [TB-1:0] b);
    logic signed [TB:0] s;
    s = {a[TB-1], a} - {b[TB-1], b};
    if (s[TB] != s[TB-1]) return s[TB] ? TMIN : TMAX;
    return s[TB-1:0];
  endfunction

  function automatic logic signed [TB-1:0] clamp_in(input logic signed [TIME_W-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    if (w > IN_MAX) return TB'(IN_MAX);
    if (w < IN_MIN) return TB'(IN_MIN);
    return TB'(w);
  endfunction

  // latched item
  op_t                  op_r;
  logic [INDEX_W-1:0]   idx_r;
  logic signed [TB-1:0] tv_r;
  logic                 wrap_r;
  logic                 ok_r;

  // configuration and cursor
  logic [CFG_W-1:0]     frame_count;
  logic [AW-1:0]        seg;
  logic signed [TB-1:0] clock;

  // search and step registers
  logic signed [TB-1:0] t0_r, tl_r, lo, hi, dur;
  logic [AW-1:0]        i_idx, j_idx;
  logic [CW-1:0]        step;
  logic                 above_r;

  // table port
  logic [AW-1:0]        raddr;
  logic [TB-1:0]        rdata;
  logic signed [TB-1:0] rd_val;

  logic [CW-1:0]        n_c;
  logic [AW:0]          sum_ij;
  logic [AW-1:0]        k_idx;
  logic                 above, seg_top, seg_zero;

  assign rd_val = rdata;
  assign n_c    = (CW'(frame_count) > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(frame_count);
  assign sum_ij = {1'b0, i_idx} + {1'b0, j_idx};
  assign k_idx  = sum_ij[AW:1];

  assign above    = clock > hi;
  assign seg_top  = (CW'(seg) + CW'(2)) >= n_c;
  assign seg_zero = (seg == '0);

  always_comb begin
    status.op        = op_r;
    status.idx_ok    = IW'(idx_r) < IW'(MAX_FRAMES);
    status.n_lt2     = n_c < CW'(MIN_FRAMES);
    status.span_bad  = (lo > hi) || (tv_r < lo) || (tv_r > hi);
    status.seek_last = (CW'(i_idx) + CW'(1)) == CW'(j_idx);
    status.mid_bad   = (rd_val < lo) || (rd_val > hi);
    status.adv_bad   = (n_c < CW'(MIN_FRAMES)) || ((CW'(seg) + CW'(1)) >= n_c);
    status.lo_gt_hi  = lo > hi;
    status.in_range  = (clock >= lo) && (clock <= hi);
    status.adv_clamp = !wrap_r && (above ? seg_top : seg_zero);
    status.step_last = (step + CW'(1)) >= n_c;
  end

  always_comb begin
    case (cmd.addr_sel)
      ADDR_ZERO: raddr = '0;
      ADDR_LAST: raddr = AW'(n_c - CW'(1));
      ADDR_SEG:  raddr = seg;
      ADDR_SEG1: raddr = AW'(CW'(seg) + CW'(1));
      ADDR_MID:  raddr = k_idx;
      ADDR_STEP: begin
        if (above) begin
          raddr = seg_top ? AW'(1) : AW'(CW'(seg) + CW'(2));
        end else begin
          raddr = seg_zero ? AW'(n_c - CW'(2)) : seg - AW'(1);
        end
      end
      default:   raddr = '0;
    endcase
  end

  kce_ram #(
    .WIDTH(TB),
    .DEPTH(MAX_FRAMES)
  ) u_table (
    .clk  (clk),
    .we   (cmd.ram_we),
    .waddr(AW'(idx_r)),
    .wdata(tv_r),
    .raddr(raddr),
    .rdata(rdata)
  );

  // cursor and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      seg         <= '0;
      clock       <= '0;
    end else begin
      if (cfg_valid) begin
        frame_count <= cfg_data;
      end
      if (cmd.seek_done) begin
        seg   <= i_idx;
        clock <= tv_r;
      end
      if (cmd.adv_add) begin
        clock <= sat_add(clock, tv_r);
      end
      if (cmd.adv_step) begin
        if (above) begin
          if (seg_top) begin
            if (wrap_r) begin
              seg   <= '0;
              clock <= sat_sub(clock, dur);
            end else begin
              clock <= tl_r;
            end
          end else begin
            seg <= seg + AW'(1);
          end
        end else begin
          if (seg_zero) begin
            if (wrap_r) begin
              seg   <= AW'(n_c - CW'(2));
              clock <= sat_add(clock, dur);
            end else begin
              clock <= t0_r;
            end
          end else begin
            seg <= seg - AW'(1);
          end
        end
      end
    end
  end

  // item, search bounds and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(opcode);
      idx_r  <= frame_index;
      tv_r   <= clamp_in(time_value);
      wrap_r <= loop_enable;
      ok_r   <= 1'b0;
      step   <= '0;
    end
    if (cmd.ok_set) begin
      ok_r <= 1'b1;
    end
    if (cmd.cap_t0) begin
      t0_r <= rd_val;
    end
    if (cmd.cap_tl) begin
      tl_r <= rd_val;
    end
    if (cmd.cap_lo) begin
      lo  <= rd_val;
      dur <= sat_sub(tl_r, t0_r);
    end
    if (cmd.cap_hi) begin
      hi <= rd_val;
    end
    if (cmd.seek_init) begin
      i_idx <= '0;
      j_idx <= AW'(n_c - CW'(1));
    end
    if (cmd.seek_step) begin
      if (tv_r <= rd_val) begin
        j_idx <= k_idx;
        hi    <= rd_val;
      end else begin
        i_idx <= k_idx;
        lo    <= rd_val;
      end
    end
    if (cmd.adv_step) begin
      above_r <= above;
      step    <= step + CW'(1);
      if (above) begin
        lo <= (seg_top && wrap_r) ? t0_r : hi;
      end else begin
        hi <= (seg_zero && wrap_r) ? tl_r : lo;
      end
    end
    // the freshly read bound lands on the side the cursor moved toward
    if (cmd.adv_cap) begin
      if (above_r) begin
        hi <= rd_val;
      end else begin
        lo <= rd_val;
      end
    end
    if (cmd.out_load) begin
      ok            <= ok_r;
      segment_index <= SEG_W'(seg);
      cursor_time   <= TIME_W'(clock);
    end
  end

  a_seek_lands: assert property (@(posedge clk) disable iff (rst)
    cmd.seek_done |=> (clock == $past(tv_r)))
    else $error("seek did not move the cursor to the requested time");

endmodule

// ===== hdl/kce_ctrl.sv =====
// ----------------------------------------------------------------------------
// kce_ctrl
// controller: sequences table writes and reads for write, seek and advance, and owns
// the input and result handshakes
// ----------------------------------------------------------------------------
module kce_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_valid,
  output logic               s_ready,
  output logic               m_valid,
  input  logic               m_ready,
  input  kce_pkg::kce_stat_t status,
  output kce_pkg::kce_cmd_t  cmd
);

  import kce_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE    = 15'b000000000000001,
    ST_DECODE  = 15'b000000000000010,
    ST_SK_T0   = 15'b000000000000100,
    ST_SK_TN   = 15'b000000000001000,
    ST_SK_SPAN = 15'b000000000010000,
    ST_SK_LOOP = 15'b000000000100000,
    ST_SK_MID  = 15'b000000001000000,
    ST_AD_ADD  = 15'b000000010000000,
    ST_AD_RD1  = 15'b000000100000000,
    ST_AD_RD2  = 15'b000001000000000,
    ST_AD_RD3  = 15'b000010000000000,
    ST_AD_RD4  = 15'b000100000000000,
    ST_AD_CHK  = 15'b001000000000000,
    ST_AD_CAP  = 15'b010000000000000,
    ST_FIN     = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  assign s_ready = (state == ST_IDLE) && !rst;

  always_comb begin
    cmd          = '0;
    cmd.addr_sel = ADDR_ZERO;
    state_next   = state;
    case (state)
      ST_IDLE: begin
        if (s_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status.op)
          OP_WRITE: begin
            if (status.idx_ok) begin
              cmd.ram_we = 1'b1;
              cmd.ok_set = 1'b1;
            end
            state_next = ST_FIN;
          end
          OP_SEEK: begin
            cmd.addr_sel = ADDR_ZERO;
            state_next   = status.n_lt2 ? ST_FIN : ST_SK_T0;
          end
          OP_ADVANCE: state_next = ST_AD_ADD;
          default:    state_next = ST_FIN;
        endcase
      end
      ST_SK_T0: begin
        cmd.cap_lo   = 1'b1;
        cmd.addr_sel = ADDR_LAST;
        state_next   = ST_SK_TN;
      end
      ST_SK_TN: begin
        cmd.cap_hi    = 1'b1;
        cmd.seek_init = 1'b1;
        state_next    = ST_SK_SPAN;
      end
      ST_SK_SPAN: begin
        state_next = status.span_bad ? ST_FIN : ST_SK_LOOP;
      end
      ST_SK_LOOP: begin
        if (status.seek_last) begin
          cmd.seek_done = 1'b1;
          cmd.ok_set    = 1'b1;
          state_next    = ST_FIN;
        end else begin
          cmd.addr_sel = ADDR_MID;
          state_next   = ST_SK_MID;
        end
      end
      ST_SK_MID: begin
        if (status.mid_bad) begin
          state_next = ST_FIN;
        end else begin
          cmd.seek_step = 1'b1;
          state_next    = ST_SK_LOOP;
        end
      end
      ST_AD_ADD: begin
        // delta goes in even when the step search fails
        cmd.adv_add  = 1'b1;
        cmd.addr_sel = ADDR_ZERO;
        state_next   = status.adv_bad ? ST_FIN : ST_AD_RD1;
      end
      ST_AD_RD1: begin
        cmd.cap_t0   = 1'b1;
        cmd.addr_sel = ADDR_LAST;
        state_next   = ST_AD_RD2;
      end
      ST_AD_RD2: begin
        cmd.cap_tl   = 1'b1;
        cmd.addr_sel = ADDR_SEG;
        state_next   = ST_AD_RD3;
      end
      ST_AD_RD3: begin
        cmd.cap_lo   = 1'b1;
        cmd.addr_sel = ADDR_SEG1;
        state_next   = ST_AD_RD4;
      end
      ST_AD_RD4: begin
        cmd.cap_hi = 1'b1;
        state_next = ST_AD_CHK;
      end
      ST_AD_CHK: begin
        if (status.lo_gt_hi) begin
          state_next = ST_FIN;
        end else if (status.in_range) begin
          cmd.ok_set = 1'b1;
          state_next = ST_FIN;
        end else begin
          cmd.adv_step = 1'b1;
          cmd.addr_sel = ADDR_STEP;
          if (status.adv_clamp || status.step_last) begin
            state_next = ST_FIN;
          end else begin
            state_next = ST_AD_CAP;
          end
        end
      end
      ST_AD_CAP: begin
        cmd.adv_cap = 1'b1;
        state_next  = ST_AD_CHK;
      end
      ST_FIN: begin
        if (!m_valid || m_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    (s_valid && s_ready) |=> (state == ST_DECODE))
    else $error("accepted item not decoded next cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_valid || m_ready))
    else $error("result register overwritten while still held");

  a_write_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.ram_we |-> (status.op == OP_WRITE && status.idx_ok))
    else $error("table write outside a legal write item");

endmodule

// ===== hdl/keyframe_cursor_engine.sv =====
// ----------------------------------------------------------------------------
// keyframe_cursor_engine
// keyframe time table with a playback cursor: write, binary seek, advance
// ----------------------------------------------------------------------------
//  channel   signals                        transfer when
//  --------  -----------------------------  -----------------------------
//  s_axis    tvalid tready tdata tuser      tvalid && tready
//  m_axis    tvalid tready tdata tuser      tvalid && tready
//  cfg       cfg_valid cfg_ready cfg_data   cfg_valid && cfg_ready
//
//  one item at a time; write or unused opcode: decode, then the result register
//  seek: binary search over the table, one table read per probe
//  advance: one table read per segment stepped, one table read port
//  reset clears cursor and frame count; the table is undefined until written
//  a waiting result does not block the next item from being accepted
// ----------------------------------------------------------------------------
module keyframe_cursor_engine #(
  parameter int MAX_FRAMES = kce_pkg::FRAMES_DEF,
  parameter int TIME_BITS  = kce_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // frame_index[5:0], time_value[37:6], loop_enable[38], zero pad [39]
  input  logic [kce_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // opcode[1:0]
  input  logic [kce_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // segment_index[5:0], cursor_time[37:6], zero pad [39:38]
  output logic [kce_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // ok[0]
  output logic                              m_axis_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kce_pkg::CFG_W-1:0]         cfg_data
);

  import kce_pkg::*;

  kce_cmd_t                  cmd;
  kce_stat_t                 status;
  logic [SEG_W-1:0]          seg_out;
  logic signed [TIME_W-1:0]  time_out;

  assign cfg_ready    = !rst;
  assign m_axis_tdata = {{(OUT_DATA_W - SEG_W - TIME_W){1'b0}}, time_out, seg_out};

  kce_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .s_valid(s_axis_tvalid),
    .s_ready(s_axis_tready),
    .m_valid(m_axis_tvalid),
    .m_ready(m_axis_tready),
    .status (status),
    .cmd    (cmd)
  );

  kce_dp #(
    .MAX_FRAMES(MAX_FRAMES),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .opcode       (s_axis_tuser),
    .frame_index  (s_axis_tdata[INDEX_W-1:0]),
    .time_value   (s_axis_tdata[INDEX_W+TIME_W-1:INDEX_W]),
    .loop_enable  (s_axis_tdata[INDEX_W+TIME_W]),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .ok           (m_axis_tuser),
    .segment_index(seg_out),
    .cursor_time  (time_out)
  );

endmodule
